// ----- hdl/lsed_pkg.sv -----
package lsed_pkg;

    // Debounce run length: a clean edge needs this many equal decisions in a row
    localparam int unsigned DEBOUNCE_BITS = 4;
    localparam int unsigned PAT_W         = DEBOUNCE_BITS + 1;

    // Low history bits for an off-to-on edge: a zero, then a run of ones
    localparam logic [PAT_W-1:0] ON_PAT  = {1'b0, {DEBOUNCE_BITS{1'b1}}};
    // Low history bits for an on-to-off edge: a run of ones, then a zero
    localparam logic [PAT_W-1:0] OFF_PAT = {{DEBOUNCE_BITS{1'b1}}, 1'b0};

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_MARG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MARG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd7;

    // Configuration reset values
    localparam logic [7:0] RST_FIXED_LEVEL = 8'd100;
    localparam logic [7:0] RST_ENTER_MARG  = 8'd30;
    localparam logic [7:0] RST_HOLD_MARG   = 8'd15;
    localparam logic [7:0] RST_SHORT_TICKS = 8'd10;
    localparam logic [7:0] RST_LONG_TICKS  = 8'd100;

    // Event codes, edge mode
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_RISE     = 2'd1;
    localparam logic [1:0] EV_FALL     = 2'd2;
    // Event codes, timer mode
    localparam logic [1:0] EV_SHORT_REL = 2'd1;
    localparam logic [1:0] EV_LONG_HIT  = 2'd2;
    localparam logic [1:0] EV_SHORT_HIT = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'hff;

    typedef struct packed {
        logic       timer_mode;
        logic       fixed_level_enable;
        logic [7:0] fixed_level;
        logic [7:0] enter_margin;
        logic [7:0] hold_margin;
        logic [7:0] short_ticks;
        logic [7:0] long_ticks;
        logic [1:0] invert_flags;
    } t_cfg;

    typedef struct packed {
        logic [1:0] event_res;
        logic       on_now;
    } t_result;

endpackage

// ----- hdl/lsed_eval.sv -----
module lsed_eval (
    input  lsed_pkg::t_cfg                   i_cfg,
    input  logic [lsed_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [7:0]                       i_baseline,
    input  logic [7:0]                       i_hoc,
    output logic [7:0]                       o_baseline,
    output logic [7:0]                       o_hoc,
    output lsed_pkg::t_result                o_res
);

    logic [7:0] s;
    logic [7:0] b_load;
    logic [7:0] base;
    logic [7:0] margin;
    logic       was_on;
    logic       decide;
    logic [7:0] hist;
    logic [7:0] cnt_inc;

    // Optional sample complement
    assign s = i_cfg.invert_flags[0] ? ~i_sample : i_sample;

    // Track baseline: load when empty, creep up by one, drop at once
    always_comb begin
        b_load = (i_baseline == 8'd0) ? s : i_baseline;
        if (s > b_load) begin
            o_baseline = b_load + 8'd1;
        end else if (s < b_load) begin
            o_baseline = s;
        end else begin
            o_baseline = b_load;
        end
    end

    // Hysteresis compare against the updated baseline or the fixed level
    assign base   = i_cfg.fixed_level_enable ? i_cfg.fixed_level : o_baseline;
    assign was_on = i_cfg.timer_mode ? (i_hoc != 8'd0) : i_hoc[0];
    assign margin = was_on ? i_cfg.hold_margin : i_cfg.enter_margin;
    assign decide = {1'b0, s} > ({1'b0, base} + {1'b0, margin});

    assign cnt_inc = (i_hoc == lsed_pkg::COUNT_MAX) ? lsed_pkg::COUNT_MAX : i_hoc + 8'd1;

    // Edge reporting or on-duration timing
    always_comb begin
        hist            = {i_hoc[6:0], decide ^ i_cfg.invert_flags[1]};
        o_res.event_res = lsed_pkg::EV_NONE;
        o_res.on_now    = 1'b0;
        o_hoc           = 8'd0;
        if (i_cfg.timer_mode) begin
            o_res.on_now = decide;
            if (decide) begin
                o_hoc = cnt_inc;
                if (cnt_inc == i_cfg.long_ticks) begin
                    o_res.event_res = lsed_pkg::EV_LONG_HIT;
                end else if (cnt_inc == i_cfg.short_ticks) begin
                    o_res.event_res = lsed_pkg::EV_SHORT_HIT;
                end
            end else begin
                if ((i_hoc <= i_cfg.long_ticks) && (i_hoc > i_cfg.short_ticks)) begin
                    o_res.event_res = lsed_pkg::EV_SHORT_REL;
                end
            end
        end else begin
            o_hoc        = hist;
            o_res.on_now = hist[0];
            if (hist[lsed_pkg::PAT_W-1:0] == lsed_pkg::ON_PAT) begin
                o_res.event_res = lsed_pkg::EV_RISE;
            end else if (hist[lsed_pkg::PAT_W-1:0] == lsed_pkg::OFF_PAT) begin
                o_res.event_res = lsed_pkg::EV_FALL;
            end
        end
    end

endmodule

// ----- hdl/light_sensor_event_detector_unit.sv -----
// Light sensor event detector. Takes one 8-bit sample per transfer on the
// slave stream and returns exactly one result per sample on the master
// stream: tdata[1:0] is the event code, tdata[2] the current on decision.
// A sample passes an input register and a result register. Its result is
// presented on the master stream when the sample moves on to the result
// register, which waits while an earlier result is untaken. A new sample is
// taken in every cycle as long as the result side keeps up. The baseline and
// the history/count register are updated as the sample leaves the input
// register, which keeps one sample per cycle. Write configuration through
// the i_cfg_* port only while no sample is in flight.
module light_sensor_event_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [lsed_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsed_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Sample stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lsed_pkg::SAMPLE_W-1:0]       i_s_tdata,   // [7:0] sample
    // Result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lsed_pkg::OUT_DATA_W-1:0]     o_m_tdata    // [1:0] event_res, [2] on_now
);

    lsed_pkg::t_cfg                 r_cfg;
    logic                           r_in_valid;
    logic [lsed_pkg::SAMPLE_W-1:0]  r_in_sample;
    logic                           r_out_valid;
    lsed_pkg::t_result              r_out;
    logic [7:0]                     r_baseline;
    logic [7:0]                     r_hoc;

    logic [7:0]                     n_baseline;
    logic [7:0]                     n_hoc;
    lsed_pkg::t_result              n_out;
    logic                           advance;
    logic                           in_xfer;

    // Move the held sample forward when the result register is free or its result is being taken
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(lsed_pkg::OUT_DATA_W - 3){1'b0}}, r_out.on_now, r_out.event_res};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_mode         <= 1'b0;
            r_cfg.fixed_level_enable <= 1'b0;
            r_cfg.fixed_level        <= lsed_pkg::RST_FIXED_LEVEL;
            r_cfg.enter_margin       <= lsed_pkg::RST_ENTER_MARG;
            r_cfg.hold_margin        <= lsed_pkg::RST_HOLD_MARG;
            r_cfg.short_ticks        <= lsed_pkg::RST_SHORT_TICKS;
            r_cfg.long_ticks         <= lsed_pkg::RST_LONG_TICKS;
            r_cfg.invert_flags       <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsed_pkg::REG_TIMER_MODE:  r_cfg.timer_mode         <= i_cfg_data[0];
                lsed_pkg::REG_FIXED_EN:    r_cfg.fixed_level_enable <= i_cfg_data[0];
                lsed_pkg::REG_FIXED_LEVEL: r_cfg.fixed_level        <= i_cfg_data;
                lsed_pkg::REG_ENTER_MARG:  r_cfg.enter_margin       <= i_cfg_data;
                lsed_pkg::REG_HOLD_MARG:   r_cfg.hold_margin        <= i_cfg_data;
                lsed_pkg::REG_SHORT_TICKS: r_cfg.short_ticks        <= i_cfg_data;
                lsed_pkg::REG_LONG_TICKS:  r_cfg.long_ticks         <= i_cfg_data;
                lsed_pkg::REG_INVERT:      r_cfg.invert_flags       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Evaluate the held sample
    lsed_eval u_eval (
        .i_cfg      (r_cfg),
        .i_sample   (r_in_sample),
        .i_baseline (r_baseline),
        .i_hoc      (r_hoc),
        .o_baseline (n_baseline),
        .o_hoc      (n_hoc),
        .o_res      (n_out)
    );

    // Control: valid flags and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_baseline  <= 8'd0;
            r_hoc       <= 8'd0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_baseline  <= n_baseline;
                r_hoc       <= n_hoc;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture sample, hold result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_sample <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated sample did not reach the result register");

    a_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_cfg.timer_mode && !n_out.on_now |=> r_hoc == 8'd0)
        else $error("on count not cleared on an off decision");

    a_long_is_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_cfg.timer_mode && (n_out.event_res == lsed_pkg::EV_LONG_HIT)
        |-> n_out.on_now)
        else $error("long limit reported while off");

    a_rise_is_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_cfg.timer_mode && (n_out.event_res == lsed_pkg::EV_RISE)
        |=> r_out.on_now && r_hoc[0])
        else $error("rising edge reported without an on decision");
`endif

endmodule
